// ----- hw/rtl/tdps_pkg.sv -----
// tdps_pkg: sizes, status codes and controller states of the trial division prime sieve
// used by trial_division_prime_sieve; depends on nothing
package tdps_pkg;

  localparam int unsigned MAX_PRIMES = 256;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned TEST_W     = 16;
  localparam int unsigned STATUS_W   = 2;

  // remainder unit retires this many dividend bits per cycle
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int unsigned STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int unsigned CNT_W = $clog2(MAX_PRIMES + 1);
  localparam int unsigned IDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_EQUAL      = 2'd0,
    ST_COMPOSITE  = 2'd1,
    ST_NEW_STORED = 2'd2,
    ST_NEW_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DONE
  } state_e;

endpackage

// ----- hw/rtl/trial_division_prime_sieve.sv -----
// trial_division_prime_sieve: classifies candidates against a memory of primes found so far
// depends on tdps_pkg
//
// One candidate word is taken at a time. It is compared with the stored primes in insertion
// order, stopping at the first match or divisor, and divided by each in a remainder unit that
// retires DIV_BITS dividend bits per cycle; every table entry costs one memory read followed
// by DIV_STEPS remainder steps. A new prime walks all stored primes. The prime memory has a
// single read port. Candidates 0 and 1 are classified composite without a memory read. A
// new prime is written into the memory, unless it is full, while its result word is handed
// to the output register, which holds it until taken while the next candidate may already
// be accepted. No clearing pass is needed: only entries below the prime count are ever read.
module trial_division_prime_sieve (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tdps_pkg::TEST_W-1:0]   test_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tdps_pkg::STATUS_W-1:0] status_o,
  output logic                          is_prime_o
);
  import tdps_pkg::*;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      idx_nxt;
  logic [VALUE_BITS-1:0] cand_q, cand_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] rem_nxt;
  logic [DIV_W-1:0]      shift_q, shift_d;
  logic [STEP_W-1:0]     step_q, step_d;
  status_e               verdict_q, verdict_d;
  status_e               status_q, status_d;
  logic                  out_valid_q, out_valid_d;

  logic [VALUE_BITS-1:0] in_value;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] rd_data_q;
  logic                  wr_en;

  logic [VALUE_BITS-1:0] prime_mem [MAX_PRIMES];

  assign in_value = VALUE_BITS'(test_value_i);
  assign idx_nxt  = idx_q + CNT_W'(1);

  // prime memory, one read port with registered data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prime_mem[count_q[IDX_W-1:0]] <= cand_q;
    end
    if (rd_en) begin
      rd_data_q <= prime_mem[rd_addr];
    end
  end

  // DIV_BITS restoring steps; remainder stays below the divisor
  always_comb begin
    logic [VALUE_BITS:0]   t;
    logic [VALUE_BITS-1:0] r;
    r = rem_q;
    for (int k = 0; k < int'(DIV_BITS); k++) begin
      t = {r, shift_q[DIV_W-1-k]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r = t[VALUE_BITS-1:0];
    end
    rem_nxt = r;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cand_d      = cand_q;
    div_d       = div_q;
    rem_d       = rem_q;
    shift_d     = shift_q;
    step_d      = step_q;
    verdict_d   = verdict_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = idx_q[IDX_W-1:0];
    wr_en       = 1'b0;
    in_ready_o  = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cand_d = in_value;
          idx_d  = '0;
          if (in_value < VALUE_BITS'(2)) begin
            verdict_d = ST_COMPOSITE;
            state_d   = S_DONE;
          end else if (count_q == '0) begin
            verdict_d = ST_NEW_STORED;
            state_d   = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (rd_data_q == cand_q) begin
          verdict_d = ST_EQUAL;
          state_d   = S_DONE;
        end else begin
          div_d   = rd_data_q;
          rem_d   = '0;
          shift_d = DIV_W'(cand_q);
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d   = rem_nxt;
        shift_d = shift_q << DIV_BITS;
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          if (rem_nxt == '0) begin
            verdict_d = ST_COMPOSITE;
            state_d   = S_DONE;
          end else if (idx_nxt == count_q) begin
            verdict_d = (count_q == CNT_W'(MAX_PRIMES)) ? ST_NEW_FULL : ST_NEW_STORED;
            state_d   = S_DONE;
          end else begin
            idx_d   = idx_nxt;
            rd_en   = 1'b1;
            rd_addr = idx_nxt[IDX_W-1:0];
            state_d = S_READ;
          end
        end
      end
      S_DONE: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = verdict_q;
          if (verdict_q == ST_NEW_STORED) begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cand_q    <= cand_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    shift_q   <= shift_d;
    step_q    <= step_d;
    verdict_q <= verdict_d;
    status_q  <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign is_prime_o  = (status_q != ST_COMPOSITE);

endmodule
